// ===== rtl/stp_pkg.sv =====
// Shared constants and types for the short-term synaptic plasticity unit.
// Holds default sizes, register reset values, operation codes and register indexes.
// No dependencies.
package stp_pkg;

  localparam int NEURONS_DEFAULT       = 1024;
  localparam int FRACTION_BITS_DEFAULT = 24;

  localparam int NEURON_WIDTH    = 10;
  localparam int REG_INDEX_WIDTH = 2;

  localparam longint unsigned UJUMP_RESET        = 64'd167772;
  localparam longint unsigned DEPRESSION_RESET   = 64'd8389;
  localparam longint unsigned FACILITATION_RESET = 64'd1678;

  typedef enum logic [1:0] {
    OP_SPIKE = 2'd0,
    OP_TICK  = 2'd1,
    OP_BLOCK = 2'd2,
    OP_CLEAR = 2'd3
  } stp_op_t;

  localparam logic [REG_INDEX_WIDTH-1:0] REG_UJUMP        = 2'd0;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_DEPRESSION   = 2'd1;
  localparam logic [REG_INDEX_WIDTH-1:0] REG_FACILITATION = 2'd2;

endpackage

// ===== rtl/short_term_synaptic_plasticity_unit.sv =====
// Short-term plasticity unit: a spike passes read, multiply and write-back states, waiting in
// write-back while the previous result is held; a tick takes every neuron through them;
// a clear sweeps all entries, a block sets a flag. No request is taken until idle. One shared
// multiplier and a single-port state memory serve all. After reset it sweeps all NEURONS
// entries with in_stall high before any request. Depends on stp_pkg, stp_mul_unit, stp_store.
module short_term_synaptic_plasticity_unit #(
  parameter int NEURONS       = stp_pkg::NEURONS_DEFAULT,
  parameter int FRACTION_BITS = stp_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [stp_pkg::REG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [FRACTION_BITS:0]               cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [1:0]                           operation,
  input  logic [stp_pkg::NEURON_WIDTH-1:0]     neuron,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [stp_pkg::NEURON_WIDTH-1:0]     source_neuron,
  output logic [FRACTION_BITS:0]               efficacy,
  output logic                                 forwarded
);
  import stp_pkg::*;

  localparam int W  = FRACTION_BITS + 1;
  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1;
  localparam longint unsigned ONE_L = 64'd1 << FRACTION_BITS;
  localparam logic [W-1:0] ONE_Q = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [W-1:0] UJUMP_INIT =
    (UJUMP_RESET > ONE_L) ? ONE_Q : W'(UJUMP_RESET);
  localparam logic [W-1:0] DEPRESSION_INIT =
    (DEPRESSION_RESET > ONE_L) ? ONE_Q : W'(DEPRESSION_RESET);
  localparam logic [W-1:0] FACILITATION_INIT =
    (FACILITATION_RESET > ONE_L) ? ONE_Q : W'(FACILITATION_RESET);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NEURONS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BLOCK,
    S_READ,
    S_MUL1,
    S_MUL2,
    S_WB,
    S_SWEEP
  } state_t;

  state_t           state;
  stp_op_t          op;
  logic [AW-1:0]    addr;
  logic             sweep_init;
  logic [NEURON_WIDTH-1:0] src;
  logic [W-1:0]     ujump;
  logic [W-1:0]     depression_rate;
  logic [W-1:0]     facilitation_rate;
  logic [W-1:0]     nx;
  logic [W-1:0]     eff;

  logic [W-1:0]     x_rd;
  logic [W-1:0]     u_rd;
  logic             blk_rd;
  logic [W-1:0]     mul_a;
  logic [W-1:0]     mul_b;
  logic [W-1:0]     product;
  logic [W-1:0]     cfg_sat;
  logic             in_range;
  logic             accept;
  logic             is_spike;
  logic             u_below;
  logic [W-1:0]     u_diff;
  logic [W:0]       x_sum;
  logic [W:0]       u_sum;
  logic [W-1:0]     x_new;
  logic [W-1:0]     u_new;
  logic             wb_go;
  logic             mem_we;
  logic             blk_we;
  logic [W-1:0]     x_wdata;
  logic [W-1:0]     u_wdata;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign in_range = (32'(neuron) < NEURONS);
  assign is_spike = (op == OP_SPIKE);
  assign cfg_sat  = (cfg_data > ONE_Q) ? ONE_Q : cfg_data;

  assign u_below = (u_rd < ujump);
  assign u_diff  = u_below ? (ujump - u_rd) : (u_rd - ujump);

  // First product arrives in S_MUL2, second in S_WB. The second pair of operands is held
  // through write-back so the product stays put while a spike waits there.
  always_comb begin
    mul_a = x_rd;
    mul_b = u_rd;
    case (state)
      S_MUL1: begin
        if (is_spike) begin
          mul_a = x_rd;
          mul_b = u_rd;
        end else begin
          mul_a = depression_rate;
          mul_b = ONE_Q - x_rd;
        end
      end
      S_MUL2, S_WB: begin
        if (is_spike) begin
          mul_a = ujump;
          mul_b = ONE_Q - u_rd;
        end else begin
          mul_a = facilitation_rate;
          mul_b = u_diff;
        end
      end
      default: begin
        mul_a = x_rd;
        mul_b = u_rd;
      end
    endcase
  end

  stp_mul_unit #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .product(product)
  );

  always_comb begin
    x_sum = {1'b0, x_rd} + {1'b0, product};
    u_sum = {1'b0, u_rd} + {1'b0, product};
    if (is_spike) begin
      x_new = (product > x_rd) ? '0 : (x_rd - product);
      u_new = (u_sum > {1'b0, ONE_Q}) ? ONE_Q : u_sum[W-1:0];
    end else begin
      x_new = (x_sum > {1'b0, ONE_Q}) ? ONE_Q : x_sum[W-1:0];
      if (u_below) begin
        u_new = (u_sum > {1'b0, ONE_Q}) ? ONE_Q : u_sum[W-1:0];
      end else begin
        u_new = u_rd - product;
      end
    end
  end

  // A spike waits in write-back only while the previous result is still held.
  assign wb_go   = !(is_spike && out_valid && out_stall);
  assign mem_we  = ((state == S_WB) && wb_go) || (state == S_SWEEP);
  assign blk_we  = (state == S_BLOCK) || (state == S_SWEEP);
  assign x_wdata = (state == S_SWEEP) ? ONE_Q : nx;
  assign u_wdata = (state == S_SWEEP) ? (sweep_init ? UJUMP_INIT : ujump) : u_new;

  stp_store #(
    .NEURONS      (NEURONS),
    .FRACTION_BITS(FRACTION_BITS)
  ) u_store (
    .clk      (clk),
    .addr     (addr),
    .we       (mem_we),
    .x_wdata  (x_wdata),
    .u_wdata  (u_wdata),
    .blk_we   (blk_we),
    .blk_wdata(state == S_BLOCK),
    .x_rdata  (x_rd),
    .u_rdata  (u_rd),
    .blk_rdata(blk_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ujump             <= UJUMP_INIT;
      depression_rate   <= DEPRESSION_INIT;
      facilitation_rate <= FACILITATION_INIT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_UJUMP:        ujump             <= cfg_sat;
        REG_DEPRESSION:   depression_rate   <= cfg_sat;
        REG_FACILITATION: facilitation_rate <= cfg_sat;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      addr       <= '0;
      sweep_init <= 1'b1;
      op         <= OP_SPIKE;
      out_valid  <= 1'b0;
    end else begin
      if ((state == S_WB) && wb_go && is_spike) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            op  <= stp_op_t'(operation);
            src <= neuron;
            case (stp_op_t'(operation))
              OP_SPIKE: begin
                addr <= AW'(neuron);
                if (in_range) begin
                  state <= S_READ;
                end
              end
              OP_BLOCK: begin
                addr <= AW'(neuron);
                if (in_range) begin
                  state <= S_BLOCK;
                end
              end
              OP_TICK: begin
                addr  <= '0;
                state <= S_READ;
              end
              OP_CLEAR: begin
                addr       <= '0;
                sweep_init <= 1'b0;
                state      <= S_SWEEP;
              end
              default: ;
            endcase
          end
        end
        S_BLOCK: begin
          state <= S_IDLE;
        end
        S_READ: begin
          state <= S_MUL1;
        end
        S_MUL1: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          nx    <= x_new;
          eff   <= product;
          state <= S_WB;
        end
        S_WB: begin
          if (wb_go) begin
            if (is_spike) begin
              source_neuron <= src;
              efficacy      <= eff;
              forwarded     <= !blk_rd;
              state         <= S_IDLE;
            end else if (addr == LAST_ADDR) begin
              state <= S_IDLE;
            end else begin
              addr  <= addr + AW'(1);
              state <= S_READ;
            end
          end
        end
        S_SWEEP: begin
          if (addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The clearing sweep must never overlap with accepting a request.
  a_sweep_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> in_stall)
    else $error("request accepted during clearing sweep");

  // Stored values stay within 0..1.0 on every write-back.
  a_wb_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_WB) |-> (nx <= ONE_Q) && (u_new <= ONE_Q))
    else $error("state write-back out of range");

  // A new result is only raised from write-back of a spike.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_WB) && ($past(op) == OP_SPIKE))
    else $error("result raised outside spike write-back");

  // An accepted in-range spike starts its memory read next cycle.
  a_spike_start: assert property (@(posedge clk) disable iff (rst)
    (accept && (operation == OP_SPIKE) && in_range) |=> (state == S_READ))
    else $error("spike did not start its read");

  // Efficacy is a product of two values in 0..1.0.
  a_eff_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (efficacy <= ONE_Q))
    else $error("efficacy above 1.0");

endmodule

// ===== rtl/stp_mul_unit.sv =====
// Shared fixed-point multiplier: registered product of two Q1.F values,
// rounded to nearest with ties upward. Depends on stp_pkg.
module stp_mul_unit #(
  parameter int FRACTION_BITS = stp_pkg::FRACTION_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic [FRACTION_BITS:0]   a,
  input  logic [FRACTION_BITS:0]   b,
  output logic [FRACTION_BITS:0]   product
);
  import stp_pkg::*;

  localparam int W = FRACTION_BITS + 1;
  localparam logic [2*W-1:0] HALF = {{(W + 1){1'b0}}, 1'b1, {(FRACTION_BITS - 1){1'b0}}};

  logic [2*W-1:0] full;

  // Both operands never exceed 1.0, so the rounded result fits in W bits.
  assign full = ({{W{1'b0}}, a} * {{W{1'b0}}, b}) + HALF;

  always_ff @(posedge clk) begin
    product <= full[2*FRACTION_BITS:FRACTION_BITS];
  end

endmodule

// ===== rtl/stp_store.sv =====
// Per-neuron state memories: resource level, utilisation and blocked flag.
// One shared address, registered read data. Depends on stp_pkg.
module stp_store #(
  parameter int NEURONS       = stp_pkg::NEURONS_DEFAULT,
  parameter int FRACTION_BITS = stp_pkg::FRACTION_BITS_DEFAULT,
  localparam int AW = (NEURONS > 1) ? $clog2(NEURONS) : 1
) (
  input  logic                   clk,
  input  logic [AW-1:0]          addr,
  input  logic                   we,
  input  logic [FRACTION_BITS:0] x_wdata,
  input  logic [FRACTION_BITS:0] u_wdata,
  input  logic                   blk_we,
  input  logic                   blk_wdata,
  output logic [FRACTION_BITS:0] x_rdata,
  output logic [FRACTION_BITS:0] u_rdata,
  output logic                   blk_rdata
);
  import stp_pkg::*;

  logic [FRACTION_BITS:0] x_mem [NEURONS];
  logic [FRACTION_BITS:0] u_mem [NEURONS];
  logic                   blk_mem [NEURONS];

  always_ff @(posedge clk) begin
    if (we) begin
      x_mem[addr] <= x_wdata;
      u_mem[addr] <= u_wdata;
    end
    x_rdata <= x_mem[addr];
    u_rdata <= u_mem[addr];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[addr] <= blk_wdata;
    end
    blk_rdata <= blk_mem[addr];
  end

endmodule

// ===== test/tb_short_term_synaptic_plasticity_unit.sv =====
// Self-checking testbench for short_term_synaptic_plasticity_unit: directed and random
// spike, tick, block and clear requests under several register settings, with a scoreboard
// class that predicts each efficacy result. Depends on stp_pkg and the unit's RTL.
module tb_short_term_synaptic_plasticity_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import stp_pkg::*;

  localparam int NEURON_COUNT = NEURONS_DEFAULT;
  localparam int FB = FRACTION_BITS_DEFAULT;
  localparam longint unsigned UNIT = 64'd1 << FB;
  localparam int SETTLE_CYCLES = 4 * NEURON_COUNT + 64;
  localparam int LONG_HOLD = 300;

  typedef logic [FB:0] level_t;
  typedef logic [NEURON_WIDTH-1:0] index_t;
  typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;

  typedef struct {
    index_t neuron;
    level_t efficacy;
    logic   forwarded;
  } spike_result_t;

  class synapse_tracker;
    longint unsigned util_jump;
    longint unsigned recovery_rate;
    longint unsigned util_decay;
    longint unsigned resource [NEURON_COUNT];
    longint unsigned util [NEURON_COUNT];
    bit muted [NEURON_COUNT];
    spike_result_t due [$];
    int mismatches;

    function new();
      util_jump = clamp_unit(UJUMP_RESET);
      recovery_rate = clamp_unit(DEPRESSION_RESET);
      util_decay = clamp_unit(FACILITATION_RESET);
      mismatches = 0;
      refill();
    endfunction

    function longint unsigned clamp_unit(longint unsigned v);
      return (v > UNIT) ? UNIT : v;
    endfunction

    // Product of two unit-range values, rounded to nearest with ties upward.
    function longint unsigned round_mul(longint unsigned a, longint unsigned b);
      return (a * b + (UNIT >> 1)) >> FB;
    endfunction

    function void refill();
      for (int i = 0; i < NEURON_COUNT; i++) begin
        resource[i] = UNIT;
        util[i] = util_jump;
        muted[i] = 1'b0;
      end
    endfunction

    function void set_register(reg_index_t idx, level_t value);
      longint unsigned v;
      v = clamp_unit(value);
      case (idx)
        REG_UJUMP: begin
          util_jump = v;
        end
        REG_DEPRESSION: begin
          recovery_rate = v;
        end
        REG_FACILITATION: begin
          util_decay = v;
        end
        default: begin
        end
      endcase
    endfunction

    function void take_request(stp_op_t op, index_t n);
      longint unsigned x;
      longint unsigned u;
      longint unsigned drop;
      spike_result_t r;
      case (op)
        OP_TICK: begin
          for (int i = 0; i < NEURON_COUNT; i++) begin
            x = resource[i];
            u = util[i];
            resource[i] = clamp_unit(x + round_mul(recovery_rate, UNIT - x));
            if (u < util_jump) begin
              util[i] = clamp_unit(u + round_mul(util_decay, util_jump - u));
            end else begin
              util[i] = u - round_mul(util_decay, u - util_jump);
            end
          end
        end
        OP_CLEAR: begin
          refill();
        end
        OP_BLOCK: begin
          muted[n] = 1'b1;
        end
        default: begin
          x = resource[n];
          u = util[n];
          r.neuron = n;
          r.efficacy = level_t'(clamp_unit(round_mul(x, u)));
          r.forwarded = !muted[n];
          drop = round_mul(u, x);
          resource[n] = (drop > x) ? 0 : x - drop;
          util[n] = clamp_unit(u + round_mul(util_jump, UNIT - u));
          due.insert(due.size(), r);
        end
      endcase
    endfunction

    function void match_result(index_t n, level_t eff, logic fwd);
      spike_result_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: neuron %0d efficacy %0d forwarded %0b", n, eff, fwd);
        end
        return;
      end
      want = due.pop_front();
      if (want.neuron !== n || want.efficacy !== eff || want.forwarded !== fwd) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch: expected neuron %0d efficacy %0d forwarded %0b",
                   want.neuron, want.efficacy, want.forwarded);
          $display("          actual   neuron %0d efficacy %0d forwarded %0b", n, eff, fwd);
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_write = 1'b0;
  reg_index_t cfg_index = '0;
  level_t     cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] operation = OP_SPIKE;
  index_t     neuron = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  index_t     source_neuron;
  level_t     efficacy;
  logic       forwarded;

  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  synapse_tracker board;

  always #5 clk = ~clk;

  short_term_synaptic_plasticity_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .operation     (operation),
    .neuron        (neuron),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .source_neuron (source_neuron),
    .efficacy      (efficacy),
    .forwarded     (forwarded)
  );

  // Valid is left high after acceptance and only lowered when a gap follows,
  // so it never sees two assignments in one time step.
  task automatic send_request(input stp_op_t op, input index_t n);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    neuron <= n;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    board.take_request(op, n);
  endtask

  task automatic run_random(input int count);
    stp_op_t op;
    index_t n;
    int pick;
    int hot;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 88) op = OP_SPIKE;
      else if (pick < 93) op = OP_BLOCK;
      else if (pick < 97) op = OP_TICK;
      else op = OP_CLEAR;
      // Most requests go to a few hot neurons so that repeated spikes drive x and u far.
      if ($urandom_range(0, 9) < 7) begin
        hot = $urandom_range(0, 11);
        n = index_t'((hot < 6) ? hot : NEURON_COUNT - 12 + hot);
      end else begin
        n = index_t'($urandom_range(0, NEURON_COUNT - 1));
      end
      send_request(op, n);
    end
  endtask

  // Ticks and clears give no result, so after the last result the unit may still be
  // walking the store; wait out a full tick before touching the registers.
  task automatic settle();
    in_valid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input level_t jump, input level_t recover,
                                input level_t decay);
    level_t values [3];
    reg_index_t regs [3];
    values = '{jump, recover, decay};
    regs = '{REG_UJUMP, REG_DEPRESSION, REG_FACILITATION};
    for (int k = 0; k < 3; k++) begin
      cfg_write <= 1'b1;
      cfg_index <= regs[k];
      cfg_data <= values[k];
      @(posedge clk);
      board.set_register(regs[k], values[k]);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin : result_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
        board.match_result(source_neuron, efficacy, forwarded);
      end
      if (stall_left > 0) begin
        stall_left--;
        if (stall_left == 0) out_stall <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9);
        out_stall <= 1'b1;
      end
    end
  end

  initial begin : request_side
    board = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: extreme indexes, repeated spikes, and a blocked neuron that keeps
    // updating through a tick until a clear unblocks it.
    send_request(OP_SPIKE, 0);
    send_request(OP_SPIKE, 1023);
    send_request(OP_SPIKE, 0);
    send_request(OP_SPIKE, 0);
    send_request(OP_BLOCK, 1023);
    send_request(OP_SPIKE, 1023);
    send_request(OP_TICK, 0);
    send_request(OP_SPIKE, 1023);
    send_request(OP_SPIKE, 0);
    send_request(OP_CLEAR, 0);
    send_request(OP_SPIKE, 1023);
    send_request(OP_SPIKE, 0);
    send_request(OP_SPIKE, 512);
    send_request(OP_SPIKE, 511);
    run_random(90);
    settle();

    // Half-scale rates against an odd distance to 1.0 put the relaxation product
    // exactly on a half step, which must round upward.
    write_settings(25'h0800001, 25'h0800000, 25'h0800000);
    send_request(OP_CLEAR, 0);
    send_request(OP_SPIKE, 7);
    send_request(OP_TICK, 0);
    send_request(OP_SPIKE, 7);
    send_request(OP_SPIKE, 7);
    run_random(90);
    settle();

    // A jump above one saturates to 1.0, so a spike sets u to 1.0 and the next empties x.
    write_settings(25'h1FFFFFF, 25'h0000000, level_t'(UNIT));
    hold_request = 1'b1;
    run_random(90);
    settle();

    write_settings(25'h0000000, 25'h1234567, 25'h0000000);
    run_random(90);
    settle();

    write_settings(level_t'($urandom_range(0, UNIT)), level_t'($urandom_range(0, UNIT)),
                   level_t'($urandom_range(0, UNIT)));
    run_random(45);
    idling_on = 1'b0;
    run_random(45);
    settle();

    if (board.mismatches == 0 && board.due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/stp_pkg.sv
rtl/stp_mul_unit.sv
rtl/stp_store.sv
rtl/short_term_synaptic_plasticity_unit.sv
test/tb_short_term_synaptic_plasticity_unit.sv
